@@ src/tes_pkg.sv @@
`timescale 1ns / 1ps

package tes_pkg;

   localparam int BYTE_COUNT_W = 17;
   localparam int SCORE_W      = 9;
   localparam int SUM_W        = SCORE_W + 2;
   localparam int PEND_W       = 3;

   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int BYTE_LIMIT_W = 16;
   localparam int EVID_LIMIT_W = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_LIMIT     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EVIDENCE_LIMIT = 8'd1;

   localparam logic [BYTE_LIMIT_W-1:0] BYTE_LIMIT_RESET = 16'd10000;
   localparam logic [EVID_LIMIT_W-1:0] EVID_LIMIT_RESET = 8'd30;

   localparam logic [7:0] MARK_EF = 8'hEF;
   localparam logic [7:0] MARK_BB = 8'hBB;
   localparam logic [7:0] MARK_BF = 8'hBF;
   localparam logic [7:0] MARK_FE = 8'hFE;
   localparam logic [7:0] MARK_FF = 8'hFF;

   // bit i flags high byte 0x80 + i
   localparam logic [127:0] OEM_LIKE_MAP  = 128'h0000_0000_0000_0000_0000_0000_0611_C576;
   localparam logic [127:0] ANSI_LIKE_MAP = 128'h1140_0FF3_1140_0373_0000_0000_0000_0000;

   typedef enum logic [2:0] {
      ENC_ANSI    = 3'd0,
      ENC_OEM     = 3'd1,
      ENC_UTF8    = 3'd2,
      ENC_UTF16LE = 3'd3,
      ENC_UTF16BE = 3'd4
   } encoding_type;

   typedef enum logic [1:0] {
      MARK_NONE  = 2'd0,
      MARK_TWO   = 2'd2,
      MARK_THREE = 2'd3
   } mark_len_type;

   typedef struct packed {
      encoding_type encoding;
      logic [1:0]   mark_bytes;
   } result_type;

   function automatic encoding_type score_choice(
      input logic [SCORE_W-1:0] utf8,
      input logic [SCORE_W-1:0] ansi,
      input logic [SCORE_W-1:0] oem
   );
      encoding_type enc;
      if (oem > ansi) begin
         enc = (utf8 > oem) ? ENC_UTF8 : ENC_OEM;
      end else begin
         enc = (utf8 > ansi) ? ENC_UTF8 : ENC_ANSI;
      end
      return enc;
   endfunction

endpackage

@@ src/text_encoding_sniffer_unit.sv @@
`timescale 1ns / 1ps
// Path: an end transaction accepted on req is held in the input register and moves on to
// the output register, and so onto rsp, once the output register is free.
// Throughput: one transaction per cycle; req stalls only while an end transaction
// waits for a previous result that is still held in the output register.
// Reset: synchronous, active high; clears all scores, counters and the decision,
// and sets byte_limit to 10000 and evidence_limit to 30.
module text_encoding_sniffer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] data_byte
   input  logic                             req_tuser,  // [0] op (1 = end of data)
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,  // [2:0] encoding, [4:3] mark_bytes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tes_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tes_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                                in_valid_ff, in_valid_in;
   logic                                in_op_ff;
   logic [7:0]                          in_byte_ff;
   logic                                out_valid_ff, out_valid_in;
   tes_pkg::result_type                 out_result_ff;
   logic [tes_pkg::BYTE_LIMIT_W-1:0]    byte_limit_ff;
   logic [tes_pkg::EVID_LIMIT_W-1:0]    evid_limit_ff;
   tes_pkg::result_type                 core_result;
   logic                                out_free, advance, req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_op_ff || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance && in_op_ff) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   tes_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .op_end         (in_op_ff),
      .data_byte      (in_byte_ff),
      .byte_limit     (byte_limit_ff),
      .evidence_limit (evid_limit_ff),
      .result         (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         byte_limit_ff <= tes_pkg::BYTE_LIMIT_RESET;
         evid_limit_ff <= tes_pkg::EVID_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tes_pkg::REG_BYTE_LIMIT:     byte_limit_ff <= csr_data[tes_pkg::BYTE_LIMIT_W-1:0];
               tes_pkg::REG_EVIDENCE_LIMIT: evid_limit_ff <= csr_data[tes_pkg::EVID_LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance && in_op_ff) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff.mark_bytes, out_result_ff.encoding};

endmodule

@@ src/tes_core.sv @@
`timescale 1ns / 1ps

module tes_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              op_end,
   input  logic [7:0]                        data_byte,
   input  logic [tes_pkg::BYTE_LIMIT_W-1:0]  byte_limit,
   input  logic [tes_pkg::EVID_LIMIT_W-1:0]  evidence_limit,
   output tes_pkg::result_type               result
);

   logic [tes_pkg::BYTE_COUNT_W-1:0] count_ff, count_in;
   logic [tes_pkg::SCORE_W-1:0]      utf8_ff, utf8_in;
   logic [tes_pkg::SCORE_W-1:0]      ansi_ff, ansi_in;
   logic [tes_pkg::SCORE_W-1:0]      oem_ff, oem_in;
   logic [tes_pkg::PEND_W-1:0]       pend_ff, pend_in;
   logic [7:0]                       la0_ff, la0_in;
   logic [7:0]                       la1_ff, la1_in;
   logic [1:0]                       la_pos_ff, la_pos_in;
   logic                             decided_ff, decided_in;
   tes_pkg::encoding_type            dec_enc_ff, dec_enc_in;
   logic [1:0]                       dec_mark_ff, dec_mark_in;

   logic [tes_pkg::SUM_W-1:0] score_sum;
   logic                      is_first, is_second, is_third;
   logic                      mark_le, mark_be, mark_u8, mark_skip;

   always_comb begin
      count_in    = count_ff;
      utf8_in     = utf8_ff;
      ansi_in     = ansi_ff;
      oem_in      = oem_ff;
      pend_in     = pend_ff;
      la0_in      = la0_ff;
      la1_in      = la1_ff;
      la_pos_in   = la_pos_ff;
      decided_in  = decided_ff;
      dec_enc_in  = dec_enc_ff;
      dec_mark_in = dec_mark_ff;
      score_sum   = '0;

      is_first  = 1'b0;
      is_second = 1'b0;
      is_third  = 1'b0;
      mark_le   = 1'b0;
      mark_be   = 1'b0;
      mark_u8   = 1'b0;
      mark_skip = 1'b0;

      if (step && op_end) begin
         count_in    = '0;
         utf8_in     = '0;
         ansi_in     = '0;
         oem_in      = '0;
         pend_in     = '0;
         la0_in      = '0;
         la1_in      = '0;
         la_pos_in   = '0;
         decided_in  = 1'b0;
         dec_enc_in  = tes_pkg::ENC_ANSI;
         dec_mark_in = tes_pkg::MARK_NONE;
      end else if (step && !decided_ff) begin
         count_in = count_ff + tes_pkg::BYTE_COUNT_W'(1);
         if (la_pos_ff == 2'd0) la0_in = data_byte;
         if (la_pos_ff == 2'd1) la1_in = data_byte;
         if (la_pos_ff != 2'd3) la_pos_in = la_pos_ff + 2'd1;

         is_first  = (count_in == tes_pkg::BYTE_COUNT_W'(1));
         is_second = (count_in == tes_pkg::BYTE_COUNT_W'(2));
         is_third  = (count_in == tes_pkg::BYTE_COUNT_W'(3));
         mark_le   = is_second && la0_ff == tes_pkg::MARK_FF && data_byte == tes_pkg::MARK_FE;
         mark_be   = is_second && la0_ff == tes_pkg::MARK_FE && data_byte == tes_pkg::MARK_FF;
         mark_u8   = is_third && la0_ff == tes_pkg::MARK_EF && la1_ff == tes_pkg::MARK_BB
                     && data_byte == tes_pkg::MARK_BF;
         mark_skip = (is_first && data_byte >= tes_pkg::MARK_EF)
                     || (is_second && la0_ff == tes_pkg::MARK_EF
                         && data_byte == tes_pkg::MARK_BB);

         if (mark_le) begin
            decided_in  = 1'b1;
            dec_enc_in  = tes_pkg::ENC_UTF16LE;
            dec_mark_in = tes_pkg::MARK_TWO;
         end else if (mark_be) begin
            decided_in  = 1'b1;
            dec_enc_in  = tes_pkg::ENC_UTF16BE;
            dec_mark_in = tes_pkg::MARK_TWO;
         end else if (mark_u8) begin
            decided_in  = 1'b1;
            dec_enc_in  = tes_pkg::ENC_UTF8;
            dec_mark_in = tes_pkg::MARK_THREE;
         end else if (!mark_skip) begin
            // UTF-8 lead / continuation tracking
            if (data_byte[7:6] == 2'b11) begin
               if (!data_byte[5])      pend_in = 3'd1;
               else if (!data_byte[4]) pend_in = 3'd2;
               else if (!data_byte[3]) pend_in = 3'd3;
               else if (!data_byte[2]) pend_in = 3'd4;
               else if (!data_byte[1]) pend_in = 3'd5;
               else                    pend_in = 3'd0;
            end else if (pend_ff != 3'd0) begin
               if (data_byte[7:6] == 2'b10) begin
                  pend_in = pend_ff - 3'd1;
                  if (pend_ff == 3'd1) utf8_in = utf8_ff + tes_pkg::SCORE_W'(2);
               end else begin
                  pend_in = 3'd0;
               end
            end

            if (data_byte[7] && tes_pkg::ANSI_LIKE_MAP[data_byte[6:0]]) begin
               ansi_in = ansi_ff + tes_pkg::SCORE_W'(1);
            end
            if (data_byte[7] && tes_pkg::OEM_LIKE_MAP[data_byte[6:0]]) begin
               oem_in = oem_ff + tes_pkg::SCORE_W'(1);
            end

            score_sum = tes_pkg::SUM_W'(utf8_in) + tes_pkg::SUM_W'(ansi_in)
                        + tes_pkg::SUM_W'(oem_in);
            if (count_in > tes_pkg::BYTE_COUNT_W'(byte_limit)
                || score_sum > tes_pkg::SUM_W'(evidence_limit)) begin
               decided_in  = 1'b1;
               dec_enc_in  = tes_pkg::score_choice(utf8_in, ansi_in, oem_in);
               dec_mark_in = tes_pkg::MARK_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         utf8_ff     <= '0;
         ansi_ff     <= '0;
         oem_ff      <= '0;
         pend_ff     <= '0;
         la0_ff      <= '0;
         la1_ff      <= '0;
         la_pos_ff   <= '0;
         decided_ff  <= 1'b0;
         dec_enc_ff  <= tes_pkg::ENC_ANSI;
         dec_mark_ff <= tes_pkg::MARK_NONE;
      end else begin
         count_ff    <= count_in;
         utf8_ff     <= utf8_in;
         ansi_ff     <= ansi_in;
         oem_ff      <= oem_in;
         pend_ff     <= pend_in;
         la0_ff      <= la0_in;
         la1_ff      <= la1_in;
         la_pos_ff   <= la_pos_in;
         decided_ff  <= decided_in;
         dec_enc_ff  <= dec_enc_in;
         dec_mark_ff <= dec_mark_in;
      end
   end

   always_comb begin
      if (decided_ff) begin
         result.encoding   = dec_enc_ff;
         result.mark_bytes = dec_mark_ff;
      end else if (count_ff != '0) begin
         result.encoding   = tes_pkg::score_choice(utf8_ff, ansi_ff, oem_ff);
         result.mark_bytes = tes_pkg::MARK_NONE;
      end else begin
         result.encoding   = tes_pkg::ENC_ANSI;
         result.mark_bytes = tes_pkg::MARK_NONE;
      end
   end

endmodule
